[sv/mts_pkg.sv]
package mts_pkg;

  // Default stack depth; the top level takes it as a parameter.
  localparam int unsigned StackDepthDef = 256;

  // Fixed field widths.
  localparam int unsigned WeightW = 31;
  localparam int unsigned OccW    = 9;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_WEIGHT = 2'd1,
    ST_POP_EMPTY  = 2'd2,
    ST_PUSH_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_POP  = 1'b1
  } fsm_e;

endpackage

[sv/mts_ram.sv]
module mts_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/min_tracking_stack.sv]
// LIFO stack of positive 31-bit weights that reports its current minimum.
// Input channel (in_valid_i / in_stall_o) carries mode_i (0 push, 1 pop) and
// weight_i. Output channel (out_valid_o / out_stall_i) returns one result per
// input: status, the popped weight, the minimum, its valid flag and the
// occupancy after the operation.
// A push, a rejected push and a pop on an empty stack complete in the cycle
// of the input transfer; the result is visible on the following cycle.
// A pop that removes an entry takes one further state, FSM_POP, because the
// top weight and the entry below the top of the minimum stack come from
// synchronous RAMs whose read data is registered. Pushes sustain one item per
// cycle while the output is not stalled; a pop stalls the input until it completes.
// The current minimum is kept in a register next to the minimum RAM, so a
// push needs no read.
// Reset clears both stack counts and the output valid flag; the RAM contents
// are not cleared and need no clearing pass.
// A result waits in the output register while the receiver stalls; a new
// input is accepted only when that register is free or being drained.
module min_tracking_stack #(
  parameter int unsigned StackDepth = mts_pkg::StackDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic signed [31:0]          weight_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [mts_pkg::WeightW-1:0] popped_weight_o,
  output logic [mts_pkg::WeightW-1:0] min_weight_o,
  output logic                        min_valid_o,
  output logic [mts_pkg::OccW-1:0]    occupancy_o
);
  import mts_pkg::*;

  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);

  fsm_e state_q, state_d;

  logic [CW-1:0]      top_count_q, top_count_d;
  logic [CW-1:0]      min_count_q, min_count_d;
  logic [WeightW-1:0] min_top_q, min_top_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [WeightW-1:0] out_popped_q, out_popped_d;
  logic [WeightW-1:0] out_min_q, out_min_d;
  logic               out_minv_q, out_minv_d;
  logic [OccW-1:0]    out_occ_q, out_occ_d;

  logic               slot_free;
  logic               in_xfer;
  logic               w_we, m_we;
  logic [AW-1:0]      w_waddr, m_waddr, w_raddr, m_raddr;
  logic [WeightW-1:0] wdata;
  logic [WeightW-1:0] w_rdata, m_rdata;
  logic [CW-1:0]      top_m1, min_m1, min_m2;
  logic               weight_bad, stack_full, min_push;
  logic [CW+OccW-1:0] occ_ext;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != FSM_IDLE) || !slot_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign wdata      = weight_i[WeightW-1:0];
  assign weight_bad = (weight_i <= 32'sd0);
  assign stack_full = (top_count_q == CW'(StackDepth));
  assign min_push   = (min_count_q == '0) || (wdata <= min_top_q);

  assign top_m1 = top_count_q - CW'(1);
  assign min_m1 = min_count_q - CW'(1);
  assign min_m2 = min_count_q - CW'(2);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_xfer && mode_i && (top_count_q != '0)) begin
          state_d = FSM_POP;
        end
      end
      FSM_POP: state_d = FSM_IDLE;
      default: state_d = FSM_IDLE;
    endcase
  end

  // RAM controls.
  always_comb begin
    w_we    = 1'b0;
    m_we    = 1'b0;
    w_waddr = top_count_q[AW-1:0];
    m_waddr = min_count_q[AW-1:0];
    w_raddr = top_m1[AW-1:0];
    m_raddr = min_m2[AW-1:0];
    unique case (state_q)
      FSM_IDLE: begin
        if (in_xfer && !mode_i && !weight_bad && !stack_full) begin
          w_we = 1'b1;
          m_we = min_push;
        end
      end
      FSM_POP: begin
        w_we = 1'b0;
        m_we = 1'b0;
      end
      default: begin
        w_we = 1'b0;
        m_we = 1'b0;
      end
    endcase
  end

  // Stack counts, cached minimum and the result register.
  always_comb begin
    logic [CW-1:0]      new_top;
    logic [CW-1:0]      new_min;
    logic [WeightW-1:0] new_min_top;
    logic               produce;

    new_top      = top_count_q;
    new_min      = min_count_q;
    new_min_top  = min_top_q;
    produce      = 1'b0;
    out_status_d = out_status_q;
    out_popped_d = out_popped_q;

    if (state_q == FSM_POP) begin
      produce      = 1'b1;
      out_status_d = ST_OK;
      out_popped_d = w_rdata;
      new_top      = top_m1;
      if ((min_count_q != '0) && (w_rdata == min_top_q)) begin
        new_min     = min_m1;
        new_min_top = m_rdata;
      end
    end else if (in_xfer) begin
      out_popped_d = '0;
      if (mode_i) begin
        // A pop of a non-empty stack finishes in the next cycle.
        produce      = (top_count_q == '0);
        out_status_d = ST_POP_EMPTY;
      end else begin
        produce = 1'b1;
        if (weight_bad) begin
          out_status_d = ST_BAD_WEIGHT;
        end else if (stack_full) begin
          out_status_d = ST_PUSH_FULL;
        end else begin
          out_status_d = ST_OK;
          new_top      = top_count_q + CW'(1);
          if (min_push) begin
            new_min     = min_count_q + CW'(1);
            new_min_top = wdata;
          end
        end
      end
    end

    top_count_d = new_top;
    min_count_d = new_min;
    min_top_d   = new_min_top;

    out_valid_d = (out_valid_q && out_stall_i) || produce;
    out_minv_d  = out_minv_q;
    out_min_d   = out_min_q;
    out_occ_d   = out_occ_q;
    occ_ext     = {{OccW{1'b0}}, new_top};
    if (produce) begin
      out_minv_d = (new_top != '0) && (new_min != '0);
      out_min_d  = out_minv_d ? new_min_top : '0;
      out_occ_d  = occ_ext[OccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      top_count_q <= '0;
      min_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_count_q <= top_count_d;
      min_count_q <= min_count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_top_q    <= min_top_d;
    out_status_q <= out_status_d;
    out_popped_q <= out_popped_d;
    out_min_q    <= out_min_d;
    out_minv_q   <= out_minv_d;
    out_occ_q    <= out_occ_d;
  end

  mts_ram #(
    .Width(WeightW),
    .Depth(StackDepth)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(wdata),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  mts_ram #(
    .Width(WeightW),
    .Depth(StackDepth)
  ) u_min_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(wdata),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign popped_weight_o = out_popped_q;
  assign min_weight_o    = out_min_q;
  assign min_valid_o     = out_minv_q;
  assign occupancy_o     = out_occ_q;

endmodule

[test/min_stack_checker.sv]
package stack_op_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

endpackage

module min_stack_checker #(
  parameter int unsigned StackDepth = mts_pkg::StackDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        mode_i,
  input  logic [31:0]                 weight_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [1:0]                  status_i,
  input  logic [mts_pkg::WeightW-1:0] popped_weight_i,
  input  logic [mts_pkg::WeightW-1:0] min_weight_i,
  input  logic                        min_valid_i,
  input  logic [mts_pkg::OccW-1:0]    occupancy_i,
  output int                          failures_o,
  output int                          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;
  import stack_op_pkg::*;

  typedef struct packed {
    status_e              status;
    logic [WeightW-1:0]   popped;
    logic [WeightW-1:0]   min_w;
    logic                 min_v;
    logic [OccW-1:0]      occ;
  } stack_result_t;

  logic [WeightW-1:0] weight_mem [StackDepth];
  logic [WeightW-1:0] min_mem    [StackDepth];
  int unsigned        depth_used = 0;
  int unsigned        min_used   = 0;
  stack_result_t      expected_q [$];
  int                 failures   = 0;

  task automatic log_failure(input string msg);
    $display("%0t ns: %s", $time, msg);
    failures++;
  endtask

  // Updates the shadow stacks for one operation and returns what the block must report.
  function automatic stack_result_t apply_stack_op(input op_e op, input logic [31:0] w);
    stack_result_t r;
    r = '0;
    r.status = ST_OK;
    if (op == OP_PUSH) begin
      if (w == 32'd0 || w[31]) begin
        r.status = ST_BAD_WEIGHT;
      end else if (depth_used >= StackDepth) begin
        r.status = ST_PUSH_FULL;
      end else begin
        weight_mem[depth_used] = w[WeightW-1:0];
        depth_used++;
        if (min_used == 0) begin
          min_mem[0] = w[WeightW-1:0];
          min_used = 1;
        end else if (min_used < StackDepth && w[WeightW-1:0] <= min_mem[min_used-1]) begin
          min_mem[min_used] = w[WeightW-1:0];
          min_used++;
        end
      end
    end else if (depth_used == 0) begin
      r.status = ST_POP_EMPTY;
    end else begin
      r.popped = weight_mem[depth_used-1];
      // Ties were pushed onto the minimum stack too, so one copy leaves per pop.
      if (min_used > 0 && r.popped == min_mem[min_used-1]) min_used--;
      depth_used--;
    end
    if (depth_used > 0 && min_used > 0) begin
      r.min_w = min_mem[min_used-1];
      r.min_v = 1'b1;
    end
    r.occ = depth_used[OccW-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni) begin
      // A result never belongs to an operation accepted at the same edge, so
      // the output side is checked before the new expectation is queued.
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          log_failure($sformatf("result transfer with nothing outstanding (status %0d)",
                                status_i));
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status)
            log_failure($sformatf("status: got %0d, expected %0d", status_i, want.status));
          if (popped_weight_i !== want.popped)
            log_failure($sformatf("popped_weight: got %0h, expected %0h",
                                  popped_weight_i, want.popped));
          if (min_weight_i !== want.min_w)
            log_failure($sformatf("min_weight: got %0h, expected %0h",
                                  min_weight_i, want.min_w));
          if (min_valid_i !== want.min_v)
            log_failure($sformatf("min_valid: got %0b, expected %0b", min_valid_i, want.min_v));
          if (occupancy_i !== want.occ)
            log_failure($sformatf("occupancy: got %0d, expected %0d", occupancy_i, want.occ));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(apply_stack_op(op_e'(mode_i), weight_i));
    end
    failures_o <= failures;
    pending_o  <= expected_q.size();
  end

endmodule

[test/testbench.sv]
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;
  import stack_op_pkg::*;

  localparam int unsigned Depth       = StackDepthDef;
  localparam int unsigned RandomItems = 1230;

  typedef enum int unsigned {
    SEG_FILL,
    SEG_MIXED,
    SEG_DRAIN
  } seg_e;

  typedef enum int unsigned {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               mode      = OP_PUSH;
  logic [31:0]        weight    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [WeightW-1:0] popped_weight;
  logic [WeightW-1:0] min_weight;
  logic               min_valid;
  logic [OccW-1:0]    occupancy;
  int                 failures;
  int                 pending;

  int unsigned        burst_left  = 0;
  rx_mode_e           rx_mode     = RX_OPEN;
  int unsigned        rx_left     = 0;
  int unsigned        rx_phase    = 0;

  min_tracking_stack #(
    .StackDepth(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .weight_i       (weight),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .popped_weight_o(popped_weight),
    .min_weight_o   (min_weight),
    .min_valid_o    (min_valid),
    .occupancy_o    (occupancy)
  );

  min_stack_checker #(
    .StackDepth(Depth)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .mode_i         (mode),
    .weight_i       (weight),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .popped_weight_i(popped_weight),
    .min_weight_i   (min_weight),
    .min_valid_i    (min_valid),
    .occupancy_i    (occupancy),
    .failures_o     (failures),
    .pending_o      (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver switches at random between open, light, heavy and periodic stall patterns.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(3));
      rx_left = $urandom_range(200, 40);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:  out_stall = 1'b0;
      RX_LIGHT: out_stall = ($urandom_range(3) == 0);
      RX_HEAVY: out_stall = ($urandom_range(3) != 0);
      default:  out_stall = ((rx_phase % 7) < 3);
    endcase
  end

  // Weights lean toward small values so that ties with the minimum are common.
  function automatic logic [31:0] pick_weight();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) return ($urandom_range(1) == 0) ? 32'd0 : ($urandom() | 32'h8000_0000);
    if (sel < 45) return $urandom_range(24, 1);
    if (sel < 55) return ($urandom_range(1) == 0) ? 32'd1 : 32'h7FFF_FFFF;
    return $urandom() & 32'h7FFF_FFFF;
  endfunction

  task automatic issue_op(input op_e op, input logic [31:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid = 1'b0;
        weight   = $urandom();
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid = 1'b1;
    mode     = op;
    weight   = w;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid   = 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int unsigned issued;
    int unsigned seg_idx;
    int unsigned seg_len;
    int unsigned push_pct;
    seg_e        seg;

    issued  = 0;
    seg_idx = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty pop, rejected weights, extremes, ties on the minimum.
    issue_op(OP_POP,  $urandom());
    issue_op(OP_PUSH, 32'd0);
    issue_op(OP_PUSH, 32'hFFFF_FFFF);
    issue_op(OP_PUSH, 32'h8000_0000);
    issue_op(OP_PUSH, 32'h7FFF_FFFF);
    issue_op(OP_PUSH, 32'h4000_0000);
    issue_op(OP_PUSH, 32'd5);
    issue_op(OP_PUSH, 32'd5);
    issue_op(OP_PUSH, 32'd7);
    issue_op(OP_PUSH, 32'd1);
    issue_op(OP_PUSH, 32'h7FFF_FFFF);
    repeat (7) issue_op(OP_POP, $urandom());
    issue_op(OP_POP,  32'hFFFF_FFFF);
    issue_op(OP_PUSH, 32'd1);
    issue_op(OP_PUSH, 32'd1);
    issue_op(OP_POP,  32'd0);
    issue_op(OP_POP,  $urandom());
    wait_for_results();

    // Random: the first segments fill the stack past full and then drain it.
    while (issued < RandomItems) begin
      case (seg_idx)
        0:       seg = SEG_FILL;
        1:       seg = SEG_DRAIN;
        default: seg = seg_e'($urandom_range(2));
      endcase
      seg_len  = (seg == SEG_MIXED) ? $urandom_range(120, 20) : $urandom_range(380, 340);
      if (seg_len > RandomItems - issued) seg_len = RandomItems - issued;
      push_pct = (seg == SEG_FILL) ? 98 : (seg == SEG_DRAIN) ? 10 : 55;
      repeat (seg_len) begin
        if ($urandom_range(99) < push_pct) issue_op(OP_PUSH, pick_weight());
        else issue_op(OP_POP, $urandom());
        issued++;
      end
      if (seg_idx == 0 || $urandom_range(2) == 0) wait_for_results();
      seg_idx++;
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
